@@ rtl/sfs_pkg.sv @@
// Shared types, widths and codes for the sprite frame sequencer.
// Used by the controller, the datapath, the divider and the top level.
package sfs_pkg;

	localparam int OP_W       = 3;
	localparam int DELTA_W    = 16;
	localparam int IDX_W      = 16;
	localparam int FRAME_W    = 10;
	localparam int COUNT_W    = 11;
	localparam int PERIOD_W   = 24;
	localparam int SPEED_W    = 16;
	localparam int ACC_W      = 26;
	localparam int STEP_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int SCALE_SH   = 8;
	localparam int SCALED_W   = DELTA_W + SPEED_W - SCALE_SH;

	localparam logic [COUNT_W-1:0] MAX_FRAMES = 11'd1024;

	// divider: two quotient bits per cycle
	localparam int DIV_W      = 28;
	localparam int DIV_STEPS  = DIV_W / 2;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_START  = 3'd1,
		OP_RESUME = 3'd2,
		OP_PAUSE  = 3'd3,
		OP_STOP   = 3'd4,
		OP_SETF   = 3'd5,
		OP_ANIM   = 3'd6
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COUNT  = 2'd0,
		CFG_PERIOD = 2'd1,
		CFG_SPEED  = 2'd2,
		CFG_LOOP   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic step;
		logic wrap;
		logic out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic tick_go;
		logic need_wrap;
		logic div_done;
	} dp_status_t;

endpackage

@@ rtl/sfs_div.sv @@
// Iterative restoring divider, two quotient bits per cycle.
// Depends on sfs_pkg for widths.
module sfs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sfs_pkg::DIV_W-1:0]     dividend,
	input  logic [sfs_pkg::PERIOD_W-1:0]  divisor,
	output logic                          done,
	output logic [sfs_pkg::DIV_W-1:0]     quot,
	output logic [sfs_pkg::PERIOD_W-1:0]  rem
);
	import sfs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [PERIOD_W-1:0]  rem_q;
	logic [PERIOD_W-1:0]  dvs_q;
	logic [DIV_W-1:0]     quo_nx;
	logic [PERIOD_W-1:0]  rem_nx;

	always_comb begin
		logic [PERIOD_W:0]   t;
		logic [DIV_W-1:0]    q;
		logic [PERIOD_W-1:0] r;
		q = quo_q;
		r = rem_q;
		for (int i = 0; i < 2; i++) begin
			t = {r, q[DIV_W-1]};
			q = {q[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t = t - {1'b0, dvs_q};
				q[0] = 1'b1;
			end
			r = t[PERIOD_W-1:0];
		end
		quo_nx = q;
		rem_nx = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q)) else $error("divider done without a run");
`endif

endmodule

@@ rtl/sfs_datapath.sv @@
// Datapath: configuration, playback state, tick arithmetic and result registers.
// Depends on sfs_pkg and sfs_div; driven by commands from sfs_ctrl.
module sfs_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sfs_pkg::ctrl_cmd_t              cmd,
	output sfs_pkg::dp_status_t             status,
	input  logic                            cfg_we,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [sfs_pkg::OP_W-1:0]        op,
	input  logic [sfs_pkg::DELTA_W-1:0]     delta,
	input  logic signed [sfs_pkg::IDX_W-1:0] frame_index,
	input  logic                            pause_after,
	output logic [sfs_pkg::FRAME_W-1:0]     frame,
	output logic                            playing,
	output logic                            frame_changed,
	output logic                            ended,
	output logic                            target_reached,
	output logic                            accepted,
	output logic [sfs_pkg::STEP_W-1:0]      frames_stepped
);
	import sfs_pkg::*;

	localparam logic [STEP_W-1:0] STEP_MAX = '1;

	function automatic logic [STEP_W-1:0] sat_step(input logic [DIV_W-1:0] v);
		sat_step = (v > DIV_W'(STEP_MAX)) ? STEP_MAX : v[STEP_W-1:0];
	endfunction

	// configuration
	logic [COUNT_W-1:0]  frame_count_q;
	logic [PERIOD_W-1:0] frame_period_q;
	logic [SPEED_W-1:0]  speed_gain_q;
	logic                loop_q;

	// playback state
	logic [FRAME_W-1:0]  cur_q;
	logic [ACC_W-1:0]    acc_q;
	logic                play_q;
	logic                tgt_active_q;
	logic [FRAME_W-1:0]  tgt_frame_q;
	logic                tgt_pause_q;

	// per-item registers
	op_t                 op_q;
	logic [IDX_W-1:0]    idx_q;
	logic                pa_q;
	logic [SCALED_W-1:0] scaled_q;
	logic [FRAME_W-1:0]  old_q;
	logic [ACC_W-1:0]    dper_q;
	logic                ended_q;
	logic                reached_q;
	logic                accepted_q;
	logic [STEP_W-1:0]   stepped_q;

	// output registers
	logic [FRAME_W-1:0]  frame_q;
	logic                playing_q;
	logic                changed_q;
	logic                ended_out_q;
	logic                reached_out_q;
	logic                accepted_out_q;
	logic [STEP_W-1:0]   stepped_out_q;

	logic [COUNT_W-1:0]          cnt;
	logic [COUNT_W-1:0]          cnt_m1;
	logic                        cnt_zero;
	logic [IDX_W-2:0]            idx_pos;
	logic [FRAME_W-1:0]          tclamp;
	logic                        cur_lt;
	logic [COUNT_W-1:0]          e_val;
	logic [COUNT_W-1:0]          d_val;
	logic                        tgt_ok;
	logic [DELTA_W+SPEED_W-1:0]  prod;
	logic [ACC_W:0]              sum;
	logic [ACC_W-1:0]            acc_sat;
	logic [COUNT_W+PERIOD_W-1:0] dper_full;
	logic                        tick_go;
	logic                        n_zero;
	logic                        d_le_n;
	logic                        e_le_n;
	logic                        hit;
	logic                        need_wrap;
	logic                        div_start;
	logic [DIV_W-1:0]            div_dividend;
	logic [PERIOD_W-1:0]         div_divisor;
	logic                        div_done;
	logic [DIV_W-1:0]            div_quot;
	logic [PERIOD_W-1:0]         div_rem;
	logic [DIV_W-1:0]            wrap_dividend;

	assign cnt      = (frame_count_q > MAX_FRAMES) ? MAX_FRAMES : frame_count_q;
	assign cnt_m1   = cnt - COUNT_W'(1);
	assign cnt_zero = (cnt == '0);

	assign idx_pos = idx_q[IDX_W-2:0];
	assign tclamp  = idx_q[IDX_W-1] ? '0 :
		(idx_pos >= {{(IDX_W-1-COUNT_W){1'b0}}, cnt}) ? cnt_m1[FRAME_W-1:0] :
		idx_pos[FRAME_W-1:0];

	assign cur_lt = ({1'b0, cur_q} < cnt);
	assign e_val  = cur_lt ? (cnt - {1'b0, cur_q}) : COUNT_W'(1);
	assign d_val  = (tgt_frame_q > cur_q) ? {1'b0, tgt_frame_q - cur_q} :
		(e_val + {1'b0, tgt_frame_q});
	assign tgt_ok = tgt_active_q && ({1'b0, tgt_frame_q} < cnt) &&
		(loop_q || (d_val < e_val));

	assign prod    = {{SPEED_W{1'b0}}, delta} * {{DELTA_W{1'b0}}, speed_gain_q};
	assign sum     = {1'b0, acc_q} + {{(ACC_W+1-SCALED_W){1'b0}}, scaled_q};
	assign acc_sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
	assign dper_full = {{PERIOD_W{1'b0}}, d_val} * {{COUNT_W{1'b0}}, frame_period_q};

	assign tick_go = (op_q == OP_TICK) && play_q && !cnt_zero && (frame_period_q != '0);

	assign n_zero    = (div_quot == '0);
	assign d_le_n    = ({{(DIV_W-COUNT_W){1'b0}}, d_val} <= div_quot);
	assign e_le_n    = ({{(DIV_W-COUNT_W){1'b0}}, e_val} <= div_quot);
	assign hit       = tgt_ok && d_le_n;
	assign need_wrap = !n_zero && loop_q && !hit;

	assign wrap_dividend = cur_lt ?
		(div_quot + {{(DIV_W-FRAME_W){1'b0}}, cur_q}) : (div_quot - DIV_W'(1));

	assign div_start    = (cmd.exec && tick_go) || (cmd.step && need_wrap);
	assign div_dividend = cmd.exec ? {{(DIV_W-ACC_W){1'b0}}, acc_sat} : wrap_dividend;
	assign div_divisor  = cmd.exec ? frame_period_q : {{(PERIOD_W-COUNT_W){1'b0}}, cnt};

	sfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign status.tick_go   = tick_go;
	assign status.need_wrap = need_wrap;
	assign status.div_done  = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q  <= '0;
			frame_period_q <= '0;
			speed_gain_q   <= SPEED_W'(256);
			loop_q         <= 1'b1;
			cur_q          <= '0;
			acc_q          <= '0;
			play_q         <= 1'b0;
			tgt_active_q   <= 1'b0;
			tgt_frame_q    <= '0;
			tgt_pause_q    <= 1'b0;
			ended_q        <= 1'b0;
			reached_q      <= 1'b0;
			accepted_q     <= 1'b0;
			stepped_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_COUNT:  frame_count_q  <= cfg_data[COUNT_W-1:0];
					CFG_PERIOD: frame_period_q <= cfg_data[PERIOD_W-1:0];
					CFG_SPEED:  speed_gain_q   <= cfg_data[SPEED_W-1:0];
					CFG_LOOP:   loop_q         <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				ended_q    <= 1'b0;
				reached_q  <= 1'b0;
				accepted_q <= 1'b0;
				stepped_q  <= '0;
			end
			if (cmd.exec) begin
				case (op_q)
					OP_TICK: begin
						if (tick_go) begin
							acc_q <= acc_sat;
						end
					end
					OP_START: begin
						cur_q        <= '0;
						acc_q        <= '0;
						play_q       <= 1'b1;
						tgt_active_q <= 1'b0;
						tgt_frame_q  <= '0;
					end
					OP_RESUME: play_q <= 1'b1;
					OP_PAUSE:  play_q <= 1'b0;
					OP_STOP: begin
						play_q       <= 1'b0;
						cur_q        <= '0;
						acc_q        <= '0;
						tgt_active_q <= 1'b0;
						tgt_frame_q  <= '0;
					end
					OP_SETF: begin
						acc_q <= '0;
						if (cnt_zero) begin
							cur_q <= '0;
						end else begin
							cur_q        <= tclamp;
							tgt_active_q <= 1'b0;
							tgt_frame_q  <= '0;
						end
					end
					OP_ANIM: begin
						if (!cnt_zero) begin
							accepted_q <= 1'b1;
							if (tclamp == cur_q) begin
								if (pa_q) begin
									play_q <= 1'b0;
								end
								reached_q <= 1'b1;
							end else begin
								tgt_active_q <= 1'b1;
								tgt_frame_q  <= tclamp;
								tgt_pause_q  <= pa_q;
								play_q       <= 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			if (cmd.step && !n_zero) begin
				if (hit) begin
					cur_q        <= tgt_frame_q;
					acc_q        <= acc_q - dper_q;
					tgt_active_q <= 1'b0;
					tgt_frame_q  <= '0;
					if (tgt_pause_q) begin
						play_q <= 1'b0;
					end
					reached_q <= 1'b1;
					stepped_q <= sat_step({{(DIV_W-COUNT_W){1'b0}}, d_val});
				end else if (!loop_q && e_le_n) begin
					cur_q     <= cnt_m1[FRAME_W-1:0];
					acc_q     <= '0;
					play_q    <= 1'b0;
					ended_q   <= 1'b1;
					stepped_q <= sat_step({{(DIV_W-COUNT_W){1'b0}}, e_val});
				end else begin
					acc_q     <= {{(ACC_W-PERIOD_W){1'b0}}, div_rem};
					stepped_q <= sat_step(div_quot);
					if (!loop_q) begin
						cur_q <= cur_q + div_quot[FRAME_W-1:0];
					end
				end
			end
			if (cmd.wrap) begin
				cur_q <= div_rem[FRAME_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(op);
			idx_q    <= frame_index;
			pa_q     <= pause_after;
			scaled_q <= prod[DELTA_W+SPEED_W-1:SCALE_SH];
			old_q    <= cur_q;
		end
		if (cmd.exec) begin
			dper_q <= dper_full[ACC_W-1:0];
		end
		if (cmd.out) begin
			frame_q        <= cur_q;
			playing_q      <= play_q;
			changed_q      <= (cur_q != old_q);
			ended_out_q    <= ended_q;
			reached_out_q  <= reached_q;
			accepted_out_q <= accepted_q;
			stepped_out_q  <= stepped_q;
		end
	end

	assign frame          = frame_q;
	assign playing        = playing_q;
	assign frame_changed  = changed_q;
	assign ended          = ended_out_q;
	assign target_reached = reached_out_q;
	assign accepted       = accepted_out_q;
	assign frames_stepped = stepped_out_q;

endmodule

@@ rtl/sfs_ctrl.sv @@
// Controller state machine: sequences one command through the datapath.
// Depends on sfs_pkg for command and status structs.
module sfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sfs_pkg::dp_status_t status,
	output sfs_pkg::ctrl_cmd_t  cmd
);
	import sfs_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_DIV1 = 7'b0000100,
		S_STEP = 7'b0001000,
		S_DIV2 = 7'b0010000,
		S_WRAP = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_nx = S_EXEC;
			S_EXEC: state_nx = status.tick_go ? S_DIV1 : S_OUT;
			S_DIV1: if (status.div_done) state_nx = S_STEP;
			S_STEP: state_nx = status.need_wrap ? S_DIV2 : S_OUT;
			S_DIV2: if (status.div_done) state_nx = S_WRAP;
			S_WRAP: state_nx = S_OUT;
			S_OUT:  if (out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign cmd.load = in_valid && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);
	assign cmd.step = (state_q == S_STEP);
	assign cmd.wrap = (state_q == S_WRAP);
	assign cmd.out  = (state_q == S_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC)) else $error("transfer not executed");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out |=> out_valid_q) else $error("result not presented");
`endif

endmodule

@@ rtl/sprite_frame_sequencer_top.sv @@
// Sprite frame sequencer: one result per command. Commands and idle ticks go from the
// input transfer through execute to the output register, and the next command is taken
// only once that result is registered; an accumulating tick divides the accumulator by the
// frame period on the shared two-bit-per-cycle divider, and by the frame count when a loop wraps.
// Reset clears playback state and loads configuration defaults; a result waits in the output register.
// Depends on sfs_pkg, sfs_ctrl, sfs_datapath, sfs_div.
module sprite_frame_sequencer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sfs_pkg::OP_W-1:0]        op,
	input  logic [sfs_pkg::DELTA_W-1:0]     delta,
	input  logic signed [sfs_pkg::IDX_W-1:0] frame_index,
	input  logic                            pause_after,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sfs_pkg::FRAME_W-1:0]     frame,
	output logic                            playing,
	output logic                            frame_changed,
	output logic                            ended,
	output logic                            target_reached,
	output logic                            accepted,
	output logic [sfs_pkg::STEP_W-1:0]      frames_stepped
);
	import sfs_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	sfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	sfs_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.op             (op),
		.delta          (delta),
		.frame_index    (frame_index),
		.pause_after    (pause_after),
		.frame          (frame),
		.playing        (playing),
		.frame_changed  (frame_changed),
		.ended          (ended),
		.target_reached (target_reached),
		.accepted       (accepted),
		.frames_stepped (frames_stepped)
	);

endmodule
